/* design/mne_pkg.sv */
// ----------------------------------------------------------------------------
// mne_pkg
// Shared types, constants and helper functions of the name escape encoder.
// ----------------------------------------------------------------------------
package mne_pkg;

  // Configuration register indexes.
  localparam logic CFG_ALT_MODE = 1'b0;
  localparam logic CFG_QUOTE    = 1'b1;

  // Configuration port widths.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // Reset value of the quote character ('%').
  localparam logic [7:0] QUOTE_RESET = 8'h25;

  // Characters with a special role.
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_QMARK = 8'h3F;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic       alt_mode;
    logic [7:0] quote;
  } cfg_t;

  // Up to three result bytes caused by one input byte, in emission order.
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] len;
  } run_t;

  // Hex digit of a nibble, lower or upper case.
  function automatic logic [7:0] hex_digit(input logic [3:0] n, input logic lower);
    logic [7:0] base;
    begin
      base = lower ? 8'h61 : 8'h41;
      if (n < 4'd10) begin
        hex_digit = 8'h30 + {4'd0, n};
      end else begin
        hex_digit = base + {4'd0, n} - 8'd10;
      end
    end
  endfunction

  // Bytes that must be quoted: control codes, DEL and above, and the
  // characters that host file systems reserve.
  function automatic logic is_reserved(input logic [7:0] c);
    begin
      is_reserved = (c == 8'h5C) || (c == 8'h25) || (c == 8'h2A) || (c == 8'h3F) ||
                    (c == 8'h22) || (c == 8'h3C) || (c == 8'h3E) || (c == 8'h7C) ||
                    (c == 8'h2F) || (c < 8'h20) || (c >= 8'h7F);
    end
  endfunction

endpackage

/* design/mne_in_if.sv */
// ----------------------------------------------------------------------------
// mne_in_if
// Request channel carrying source name bytes into the encoder.
// ----------------------------------------------------------------------------
interface mne_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       first_of_name;

  modport source (output valid, output in_byte, output first_of_name, input ready);
  modport sink   (input valid, input in_byte, input first_of_name, output ready);
endinterface

/* design/mne_out_if.sv */
// ----------------------------------------------------------------------------
// mne_out_if
// Request channel carrying converted name bytes out of the encoder.
// ----------------------------------------------------------------------------
interface mne_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

/* design/mne_cfg_regs.sv */
// ----------------------------------------------------------------------------
// mne_cfg_regs
// Configuration registers: alternate mode and quote character.
// ----------------------------------------------------------------------------
module mne_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [mne_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mne_pkg::CFG_DATA_W-1:0] cfg_data,
  output mne_pkg::cfg_t                  cfg
);
  import mne_pkg::*;

  logic       alt_mode_r;
  logic [7:0] quote_r;

  // Register writes, decoded by index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alt_mode_r <= 1'b0;
      quote_r    <= QUOTE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ALT_MODE: alt_mode_r <= cfg_data[0];
        CFG_QUOTE:    quote_r    <= cfg_data[7:0];
        default:      ;
      endcase
    end
  end

  assign cfg.alt_mode = alt_mode_r;
  assign cfg.quote    = quote_r;

endmodule

/* design/mne_classify.sv */
// ----------------------------------------------------------------------------
// mne_classify
// Input register and byte classifier. Holds one accepted request, works out
// the run of result bytes it causes and tracks the previous-colon flag.
// ----------------------------------------------------------------------------
module mne_classify (
  input  logic          clk,
  input  logic          rst_n,
  mne_in_if.sink        in_chan,
  input  mne_pkg::cfg_t cfg,
  input  logic          take,
  output logic          run_valid,
  output mne_pkg::run_t run
);
  import mne_pkg::*;

  logic       in_valid_r;
  logic [7:0] byte_r;
  logic       first_r;
  logic       prev_colon_r;
  logic       in_take;
  logic       prev_colon;
  logic       exempt;
  logic       quoted;
  logic       is_colon;

  // The holding register frees up in the same cycle the emitter takes it.
  assign in_chan.ready = !in_valid_r || take;
  assign in_take       = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (take) begin
      in_valid_r <= 1'b0;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      byte_r  <= in_chan.in_byte;
      first_r <= in_chan.first_of_name;
    end
  end

  // Previous-colon flag advances when the emitter takes the byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_colon_r <= 1'b1;
    end else if (take) begin
      prev_colon_r <= is_colon;
    end
  end

  assign run_valid  = in_valid_r;
  assign prev_colon = prev_colon_r || first_r;
  assign is_colon   = (byte_r == CH_COLON);
  assign exempt     = cfg.alt_mode && ((byte_r == CH_CR) || (byte_r == CH_QMARK));
  assign quoted     = !exempt && is_reserved(byte_r);

  // Build the run of result bytes.
  always_comb begin
    run.b0  = byte_r;
    run.b1  = CH_SLASH;
    run.b2  = CH_SLASH;
    run.len = 2'd1;
    if (quoted) begin
      run.b0  = cfg.quote;
      run.b1  = hex_digit(byte_r[7:4], cfg.alt_mode);
      run.b2  = hex_digit(byte_r[3:0], cfg.alt_mode);
      run.len = 2'd3;
    end else if (is_colon) begin
      if (prev_colon) begin
        run.b0  = CH_DOT;
        run.b1  = CH_DOT;
        run.len = 2'd3;
      end else begin
        run.b0  = CH_SLASH;
        run.len = 2'd1;
      end
    end
  end

endmodule

/* design/mne_emit.sv */
// ----------------------------------------------------------------------------
// mne_emit
// Result register. Loads a run of one to three bytes and shifts it out, one
// byte per accepted request, marking the last byte of the run.
// ----------------------------------------------------------------------------
module mne_emit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          run_valid,
  input  mne_pkg::run_t run,
  output logic          take,
  mne_out_if.source     out_chan
);
  import mne_pkg::*;

  logic [1:0] rem_r;
  logic [7:0] b0_r;
  logic [7:0] b1_r;
  logic [7:0] b2_r;
  logic       out_take;
  logic       free;

  assign out_take = out_chan.valid && out_chan.ready;
  // Empty, or the final byte of the current run leaves this cycle.
  assign free     = (rem_r == 2'd0) || (out_take && (rem_r == 2'd1));
  assign take     = run_valid && free;

  // Remaining byte count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 2'd0;
    end else if (take) begin
      rem_r <= run.len;
    end else if (out_take) begin
      rem_r <= rem_r - 2'd1;
    end
  end

  // Byte shift register.
  always_ff @(posedge clk) begin
    if (take) begin
      b0_r <= run.b0;
      b1_r <= run.b1;
      b2_r <= run.b2;
    end else if (out_take) begin
      b0_r <= b1_r;
      b1_r <= b2_r;
    end
  end

  assign out_chan.valid       = (rem_r != 2'd0);
  assign out_chan.out_byte    = b0_r;
  assign out_chan.last_of_run = (rem_r == 2'd1);

endmodule

/* design/mac_name_escape_encoder.sv */
// Path: a request passes the input register, then the result register.
// Throughput: one input byte per cycle while each gives one result byte and
// the receiver is ready; a quoted byte, or a colon after a colon or at a
// name start, gives three bytes that the single result register emits one
// per cycle. Reset: configuration returns to defaults (quote '%', upper-case
// hex), the previous-colon flag is set, and input and result stages empty.
// ----------------------------------------------------------------------------
// mac_name_escape_encoder
// Top level: escapes reserved bytes of a classic path name as quote plus two
// hex digits, and turns colons into / or, after a colon or name start, ../.
// ----------------------------------------------------------------------------
module mac_name_escape_encoder (
  input  logic                           clk,
  input  logic                           rst_n,
  mne_in_if.sink                         in_chan,
  mne_out_if.source                      out_chan,
  input  logic                           cfg_we,
  input  logic [mne_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mne_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mne_pkg::*;

  cfg_t cfg;
  run_t run;
  logic run_valid;
  logic take;

  // Configuration registers.
  mne_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register and classifier.
  mne_classify u_classify (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .cfg       (cfg),
    .take      (take),
    .run_valid (run_valid),
    .run       (run)
  );

  // Result register.
  mne_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .run_valid (run_valid),
    .run       (run),
    .take      (take),
    .out_chan  (out_chan)
  );

endmodule

/* verif/mac_name_escape_encoder_tb.sv */
// ----------------------------------------------------------------------------
// mac_name_escape_encoder_tb
// Self-checking bench for the name escape encoder. A clocked driver offers
// source name bytes from a queue. A clocked monitor predicts the escaped
// bytes of every accepted request and compares each result against them.
// ----------------------------------------------------------------------------
module mac_name_escape_encoder_tb;
  import mne_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_STALL  = 300;

  // One source byte as offered to the encoder.
  typedef struct packed {
    logic [7:0] data;
    logic       start_flag;
  } name_item_t;

  // One converted byte as it should leave the encoder.
  typedef struct packed {
    logic [7:0] data;
    logic       end_of_run;
  } enc_item_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mne_in_if  in_if ();
  mne_out_if out_if ();

  mac_name_escape_encoder u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  name_item_t name_bytes_q[$];
  enc_item_t  encoded_q[$];

  // Shadow copy of the configuration and the previous-colon flag.
  logic       alt_shadow;
  logic [7:0] quote_shadow;
  logic       colon_seen;

  int src_idle_pct;
  int snk_idle_pct;
  int stall_reqs;
  int errors;
  int bytes_in;
  int bytes_out;
  int cfg_writes;
  int cycle_cnt;

  // Clock generation.
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Bytes that the encoder has to quote.
  function automatic logic needs_quote(input logic [7:0] c);
    case (c)
      8'h5C, 8'h25, 8'h2A, 8'h3F, 8'h22, 8'h3C, 8'h3E, 8'h7C, 8'h2F: needs_quote = 1'b1;
      default: needs_quote = (c < 8'h20) || (c >= 8'h7F);
    endcase
  endfunction

  // Hex digit in the case that the current mode selects.
  function automatic logic [7:0] nibble_char(input logic [3:0] n);
    if (n < 4'd10) begin
      nibble_char = 8'h30 + {4'd0, n};
    end else begin
      nibble_char = (alt_shadow ? 8'h61 : 8'h41) + {4'd0, n} - 8'd10;
    end
  endfunction

  // Queues the escaped bytes of one accepted source byte.
  function automatic void encode_byte(input logic [7:0] c, input logic start_flag);
    logic exempt;
    if (start_flag) colon_seen = 1'b1;
    exempt = alt_shadow && (c == CH_CR || c == CH_QMARK);
    if (!exempt && needs_quote(c)) begin
      encoded_q.push_back('{quote_shadow, 1'b0});
      encoded_q.push_back('{nibble_char(c[7:4]), 1'b0});
      encoded_q.push_back('{nibble_char(c[3:0]), 1'b1});
    end else if (c == CH_COLON) begin
      if (colon_seen) begin
        encoded_q.push_back('{CH_DOT, 1'b0});
        encoded_q.push_back('{CH_DOT, 1'b0});
      end
      encoded_q.push_back('{CH_SLASH, 1'b1});
    end else begin
      encoded_q.push_back('{c, 1'b1});
    end
    colon_seen = (c == CH_COLON);
  endfunction

  // Driver: keeps a request steady until it is taken, then offers the next.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      if (in_if.valid) void'(name_bytes_q.pop_front());
      if (name_bytes_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        in_if.valid         <= 1'b1;
        in_if.in_byte       <= name_bytes_q[0].data;
        in_if.first_of_name <= name_bytes_q[0].start_flag;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Monitor: predicts on every accepted request, checks every accepted result.
  always @(posedge clk) begin
    int        stall_left;
    int        stall_seen;
    enc_item_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall_left = 0;
      stall_seen = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        encode_byte(in_if.in_byte, in_if.first_of_name);
        bytes_in++;
      end
      if (out_if.valid && out_if.ready) begin
        bytes_out++;
        if (encoded_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual byte %h last %b",
                   $time, out_if.out_byte, out_if.last_of_run);
          errors++;
        end else begin
          want = encoded_q.pop_front();
          if (out_if.out_byte !== want.data || out_if.last_of_run !== want.end_of_run) begin
            $display("%0t: mismatch: expected byte %h last %b, actual byte %h last %b",
                     $time, want.data, want.end_of_run, out_if.out_byte,
                     out_if.last_of_run);
            errors++;
          end
        end
      end
      // A new long hold-off request starts a fresh count.
      if (stall_seen != stall_reqs) begin
        stall_seen = stall_reqs;
        stall_left = LONG_STALL;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
      end
    end
  end

  // Watchdog on the cycle count.
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding",
             cycle_cnt, encoded_q.size());
    $display("TEST FAILED");
    $finish;
  end

  // Writes one register and mirrors it in the shadow copy.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_ALT_MODE) alt_shadow = val[0];
    else quote_shadow = val;
    cfg_writes++;
  endtask

  // Waits until every request is taken and every result has come.
  task automatic drain;
    while (name_bytes_q.size() != 0 || in_if.valid || encoded_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic queue_byte(input logic [7:0] c, input logic start_flag);
    name_bytes_q.push_back('{c, start_flag});
  endtask

  // Picks a name byte, biased towards colons and reserved characters.
  function automatic logic [7:0] pick_name_byte();
    logic [7:0] specials[12];
    int         sel;
    specials = '{8'h5C, 8'h25, 8'h2A, 8'h3F, 8'h22, 8'h3C, 8'h3E, 8'h7C, 8'h2F,
                 8'h0D, 8'h7F, 8'h20};
    sel = $urandom_range(0, 99);
    if (sel < 30) pick_name_byte = CH_COLON;
    else if (sel < 50) pick_name_byte = specials[$urandom_range(0, 11)];
    else if (sel < 70) pick_name_byte = 8'($urandom_range(0, 255));
    else pick_name_byte = 8'($urandom_range(8'h21, 8'h7E));
  endfunction

  // Queues whole names with random content; a tenth of the marks are noise.
  task automatic queue_names(input int count);
    int n;
    int len;
    n = 0;
    while (n < count) begin
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0) queue_byte(pick_name_byte(), 1'($urandom_range(0, 1)));
        else queue_byte(pick_name_byte(), i == 0);
        n++;
      end
    end
  endtask

  // Main sequence.
  initial begin
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    in_if.valid         = 1'b0;
    in_if.in_byte       = '0;
    in_if.first_of_name = 1'b0;
    out_if.ready        = 1'b0;
    alt_shadow          = 1'b0;
    quote_shadow        = QUOTE_RESET;
    colon_seen          = 1'b1;
    src_idle_pct        = 21;
    snk_idle_pct        = 55;
    stall_reqs          = 0;
    errors              = 0;
    bytes_in            = 0;
    bytes_out           = 0;
    cfg_writes          = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Colons straight after reset, then the field extremes and every
    // reserved character under the reset configuration.
    queue_byte(CH_COLON, 1'b0);
    queue_byte(CH_COLON, 1'b0);
    queue_byte(8'h41, 1'b0);
    queue_byte(CH_COLON, 1'b0);
    queue_byte(CH_COLON, 1'b1);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h7F, 1'b0);
    queue_byte(8'h7E, 1'b0);
    queue_byte(8'h1F, 1'b0);
    queue_byte(8'h20, 1'b0);
    queue_byte(CH_CR, 1'b0);
    queue_byte(CH_QMARK, 1'b0);
    queue_byte(8'h5C, 1'b0);
    queue_byte(8'h25, 1'b0);
    queue_byte(8'h2A, 1'b0);
    queue_byte(8'h22, 1'b0);
    queue_byte(8'h3C, 1'b0);
    queue_byte(8'h3E, 1'b0);
    queue_byte(8'h7C, 1'b0);
    queue_byte(CH_SLASH, 1'b0);
    queue_byte(8'hAB, 1'b0);
    drain();

    // Alternate mode with a colon as quote character: the quote must not
    // count as a previous colon.
    write_reg(CFG_ALT_MODE, 8'h01);
    write_reg(CFG_QUOTE, CH_COLON);
    queue_byte(CH_CR, 1'b0);
    queue_byte(CH_QMARK, 1'b0);
    queue_byte(8'hAB, 1'b0);
    queue_byte(CH_COLON, 1'b0);
    queue_byte(CH_COLON, 1'b0);
    drain();

    // First random phase: the receiver holds off for a long stretch while
    // the queue is full, and the sender pauses halfway until all is out.
    write_reg(CFG_ALT_MODE, 8'h00);
    write_reg(CFG_QUOTE, 8'h00);
    queue_names(75);
    stall_reqs++;
    drain();
    queue_names(75);
    drain();

    // Second random phase with the idling swapped round.
    src_idle_pct = 55;
    snk_idle_pct = 21;
    write_reg(CFG_ALT_MODE, 8'h01);
    write_reg(CFG_QUOTE, 8'hFF);
    queue_names(140);
    drain();

    // Last random phase at full rate with a random configuration.
    src_idle_pct = 0;
    snk_idle_pct = 0;
    write_reg(CFG_ALT_MODE, 8'($urandom_range(0, 1)));
    write_reg(CFG_QUOTE, 8'($urandom_range(0, 255)));
    queue_names(140);
    drain();
    repeat (8) @(posedge clk);

    if (encoded_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, encoded_q.size());
      errors++;
    end
    $display("Covered %0d source bytes and %0d escaped bytes over %0d register writes,",
             bytes_in, bytes_out, cfg_writes);
    $display("with both idling mixes, a long receiver hold-off and %0d mismatches.", errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
